// ----- hw/rtl/awsc_pkg.sv -----
// ----------------------------------------------------------------------------
// awsc_pkg: shared types and constants of the analog wheel step counter
// Channel codes, configuration register indexes, and the configuration
// record and per-wheel result record that travel between the modules.
// ----------------------------------------------------------------------------
package awsc_pkg;

	// Field widths.
	localparam int SampleW = 8;
	localparam int CountW  = 16;
	localparam int KindW   = 2;
	localparam int IndexW  = 3;
	localparam int DataW   = 16;

	// Channel codes carried in the kind field.
	localparam logic [KindW-1:0] KIND_GOAL_LEFT   = 2'd0;
	localparam logic [KindW-1:0] KIND_GOAL_RIGHT  = 2'd1;
	localparam logic [KindW-1:0] KIND_RIGHT_WHEEL = 2'd2;
	localparam logic [KindW-1:0] KIND_LEFT_WHEEL  = 2'd3;

	// Configuration register indexes.
	localparam logic [IndexW-1:0] REG_MIN_SLOPE       = 3'd0;
	localparam logic [IndexW-1:0] REG_STEPS_MODE      = 3'd1;
	localparam logic [IndexW-1:0] REG_RIGHT_TARGET    = 3'd2;
	localparam logic [IndexW-1:0] REG_LEFT_TARGET     = 3'd3;
	localparam logic [IndexW-1:0] REG_LEFT_REFERENCE  = 3'd4;
	localparam logic [IndexW-1:0] REG_RIGHT_REFERENCE = 3'd5;
	localparam logic [IndexW-1:0] REG_LEFT_MARGIN     = 3'd6;
	localparam logic [IndexW-1:0] REG_RIGHT_MARGIN    = 3'd7;

	// Priming of the first wheel sample.
	localparam logic [SampleW-1:0] PRIME_THRESHOLD = 8'd150;
	localparam logic [SampleW-1:0] PRIME_LOW       = 8'd0;
	localparam logic [SampleW-1:0] PRIME_HIGH      = 8'd255;

	// Configuration register file.
	typedef struct packed {
		logic [SampleW-1:0] slope_limit;
		logic               steps_mode;
		logic [CountW-1:0]  right_target;
		logic [CountW-1:0]  left_target;
		logic [SampleW-1:0] left_reference;
		logic [SampleW-1:0] right_reference;
		logic [SampleW-1:0] left_margin;
		logic [SampleW-1:0] right_margin;
	} cfg_t;

	// What one wheel tracker reports for the item in flight.
	typedef struct packed {
		logic [CountW-1:0] count;
		logic              stop;
	} wheel_res_t;

endpackage

// ----- hw/rtl/awsc_if.sv -----
// ----------------------------------------------------------------------------
// awsc_if: item channels of the analog wheel step counter
// Valid/ready channels for sample items in and result items out.
// ----------------------------------------------------------------------------

// Sample channel: one tagged converter reading per item.
interface awsc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] sample;

	modport source (output valid, output kind, output sample, input ready);
	modport sink   (input valid, input kind, input sample, output ready);
endinterface

// Result channel: counts, goal status and stop pulses per item.
interface awsc_out_if;
	logic        valid;
	logic        ready;
	logic        goal_status;
	logic [15:0] right_steps;
	logic [15:0] left_steps;
	logic        stop_right;
	logic        stop_left;

	modport source (output valid, output goal_status, output right_steps,
		output left_steps, output stop_right, output stop_left, input ready);
	modport sink   (input valid, input goal_status, input right_steps,
		input left_steps, input stop_right, input stop_left, output ready);
endinterface

// ----- hw/rtl/awsc_wheel.sv -----
// ----------------------------------------------------------------------------
// awsc_wheel: step tracker for one wheel reflectance sensor
// Keeps the last sample and slope direction, counts a step on each large
// slope that reverses direction, and flags the stop condition.
// ----------------------------------------------------------------------------
module awsc_wheel (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             upd,
	input  logic [awsc_pkg::SampleW-1:0]     sample,
	input  logic [awsc_pkg::SampleW-1:0]     slope_limit,
	input  logic                             steps_mode,
	input  logic [awsc_pkg::CountW-1:0]      target,
	output awsc_pkg::wheel_res_t             res
);

	logic [awsc_pkg::SampleW-1:0] last_q;
	logic                         primed_q;
	logic                         rising_q;
	logic [awsc_pkg::CountW-1:0]  count_q;

	logic [awsc_pkg::SampleW-1:0] last_eff;
	logic [awsc_pkg::SampleW-1:0] slope;
	logic                         rising;
	logic                         moved;
	logic                         big;
	logic                         step;
	logic [awsc_pkg::CountW-1:0]  count_next;

	// Slope against the last sample; an unprimed wheel starts at the far end.
	always_comb begin
		if (primed_q) begin
			last_eff = last_q;
		end else if (sample > awsc_pkg::PRIME_THRESHOLD) begin
			last_eff = awsc_pkg::PRIME_LOW;
		end else begin
			last_eff = awsc_pkg::PRIME_HIGH;
		end
		rising = sample > last_eff;
		slope  = rising ? (sample - last_eff) : (last_eff - sample);
		moved  = upd && (sample != last_eff);
		big    = moved && (slope > slope_limit);
		// The first slope sets the direction and so never counts.
		step   = big && primed_q && (rising != rising_q);
		count_next = count_q + {{(awsc_pkg::CountW-1){1'b0}}, step};
	end

	// Report the count after this item and the stop check.
	always_comb begin
		res.count = count_next;
		res.stop  = big && steps_mode && (target != '0) && (count_next >= target);
	end

	// Wheel state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			primed_q <= 1'b0;
			rising_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (moved) begin
				last_q   <= sample;
				primed_q <= 1'b1;
				if (!primed_q || step) begin
					rising_q <= rising;
				end
			end
			count_q <= count_next;
		end
	end

`ifndef ASSERT_OFF
	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(count_q))
		else $error("wheel count changed without an item");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 16'd1))
		else $error("wheel count moved by more than one step");
	a_primed_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		moved |=> primed_q && (last_q == $past(sample)))
		else $error("wheel state not refreshed after a new sample");
`endif

endmodule

// ----- hw/rtl/awsc_goal.sv -----
// ----------------------------------------------------------------------------
// awsc_goal: goal line sensing
// Keeps the latest reading of each goal sensor, compares it against the
// reference plus margin, and lags the combined status by one goal update.
// ----------------------------------------------------------------------------
module awsc_goal (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         upd,
	input  logic                         side_right,
	input  logic [awsc_pkg::SampleW-1:0] sample,
	input  awsc_pkg::cfg_t               cfg,
	output logic                         status
);

	logic [awsc_pkg::SampleW-1:0] left_sample_q;
	logic [awsc_pkg::SampleW-1:0] right_sample_q;
	logic                         left_flag_q;
	logic                         right_flag_q;
	logic                         status_q;

	logic [awsc_pkg::SampleW-1:0] left_sample;
	logic [awsc_pkg::SampleW-1:0] right_sample;
	logic [awsc_pkg::SampleW:0]   left_thresh;
	logic [awsc_pkg::SampleW:0]   right_thresh;
	logic                         left_flag;
	logic                         right_flag;

	// Threshold is reference plus margin, kept at nine bits.
	always_comb begin
		left_sample  = (upd && !side_right) ? sample : left_sample_q;
		right_sample = (upd && side_right) ? sample : right_sample_q;
		left_thresh  = {1'b0, cfg.left_reference} + {1'b0, cfg.left_margin};
		right_thresh = {1'b0, cfg.right_reference} + {1'b0, cfg.right_margin};
		left_flag    = {1'b0, left_sample} >= left_thresh;
		right_flag   = {1'b0, right_sample} >= right_thresh;
		status       = upd ? (left_flag_q && right_flag_q) : status_q;
	end

	// Goal state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sample_q  <= '0;
			right_sample_q <= '0;
			left_flag_q    <= 1'b0;
			right_flag_q   <= 1'b0;
			status_q       <= 1'b0;
		end else if (upd) begin
			left_sample_q  <= left_sample;
			right_sample_q <= right_sample;
			left_flag_q    <= left_flag;
			right_flag_q   <= right_flag;
			status_q       <= status;
		end
	end

endmodule

// ----- hw/rtl/analog_wheel_step_counter.sv -----
// ----------------------------------------------------------------------------
// analog_wheel_step_counter: wheel step counting and goal line sensing
// Top level: configuration registers, input register, wheel and goal
// trackers, and the result register.
// ----------------------------------------------------------------------------
// Each sample item enters an input register and is applied to the wheel or
// goal state as it moves on, in the same edge that loads its result into the
// output register, so the block takes one item per clock while the output is
// not stalled; result valid is registered. The single state update per item
// is a subtract, a compare and a 16-bit increment. A new item is accepted
// while a finished result waits; only a stalled output together with a full
// input register holds ready low. Configuration must be written through the
// wr_* port only while no item is in flight; the block does not enforce this.
module analog_wheel_step_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [awsc_pkg::IndexW-1:0]   wr_index,
	input  logic [awsc_pkg::DataW-1:0]    wr_data,
	awsc_in_if.sink                       samples,
	awsc_out_if.source                    results
);

	awsc_pkg::cfg_t cfg_q;

	logic                         valid_s1;
	logic [awsc_pkg::KindW-1:0]   kind_s1;
	logic [awsc_pkg::SampleW-1:0] sample_s1;

	logic                         out_valid_q;
	logic                         goal_status_q;
	logic [awsc_pkg::CountW-1:0]  right_steps_q;
	logic [awsc_pkg::CountW-1:0]  left_steps_q;
	logic                         stop_right_q;
	logic                         stop_left_q;

	logic                         fire_s1;
	logic                         upd_goal;
	logic                         upd_right;
	logic                         upd_left;
	logic                         goal_status;
	awsc_pkg::wheel_res_t         right_res;
	awsc_pkg::wheel_res_t         left_res;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				awsc_pkg::REG_MIN_SLOPE:       cfg_q.slope_limit <= wr_data[7:0];
				awsc_pkg::REG_STEPS_MODE:      cfg_q.steps_mode <= wr_data[0];
				awsc_pkg::REG_RIGHT_TARGET:    cfg_q.right_target <= wr_data;
				awsc_pkg::REG_LEFT_TARGET:     cfg_q.left_target <= wr_data;
				awsc_pkg::REG_LEFT_REFERENCE:  cfg_q.left_reference <= wr_data[7:0];
				awsc_pkg::REG_RIGHT_REFERENCE: cfg_q.right_reference <= wr_data[7:0];
				awsc_pkg::REG_LEFT_MARGIN:     cfg_q.left_margin <= wr_data[7:0];
				awsc_pkg::REG_RIGHT_MARGIN:    cfg_q.right_margin <= wr_data[7:0];
				default:                       cfg_q <= cfg_q;
			endcase
		end
	end

	// Handshake: the item in the input register moves on when the output
	// register is empty or being emptied.
	always_comb begin
		fire_s1       = valid_s1 && (!out_valid_q || results.ready);
		samples.ready = !valid_s1 || fire_s1;
		upd_goal      = fire_s1 && ((kind_s1 == awsc_pkg::KIND_GOAL_LEFT) ||
			(kind_s1 == awsc_pkg::KIND_GOAL_RIGHT));
		upd_right     = fire_s1 && (kind_s1 == awsc_pkg::KIND_RIGHT_WHEEL);
		upd_left      = fire_s1 && (kind_s1 == awsc_pkg::KIND_LEFT_WHEEL);
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			kind_s1   <= samples.kind;
			sample_s1 <= samples.sample;
		end
	end

	// Wheel and goal trackers.
	awsc_wheel u_right (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd_right),
		.sample      (sample_s1),
		.slope_limit (cfg_q.slope_limit),
		.steps_mode  (cfg_q.steps_mode),
		.target      (cfg_q.right_target),
		.res         (right_res)
	);

	awsc_wheel u_left (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd_left),
		.sample      (sample_s1),
		.slope_limit (cfg_q.slope_limit),
		.steps_mode  (cfg_q.steps_mode),
		.target      (cfg_q.left_target),
		.res         (left_res)
	);

	awsc_goal u_goal (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd_goal),
		.side_right (kind_s1 == awsc_pkg::KIND_GOAL_RIGHT),
		.sample     (sample_s1),
		.cfg        (cfg_q),
		.status     (goal_status)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			goal_status_q <= goal_status;
			right_steps_q <= right_res.count;
			left_steps_q  <= left_res.count;
			stop_right_q  <= right_res.stop;
			stop_left_q   <= left_res.stop;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.goal_status = goal_status_q;
	assign results.right_steps = right_steps_q;
	assign results.left_steps  = left_steps_q;
	assign results.stop_right  = stop_right_q;
	assign results.stop_left   = stop_left_q;

`ifndef ASSERT_OFF
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1 && $stable(kind_s1) && $stable(sample_s1))
		else $error("item in input register lost while the output stalled");
	a_one_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(stop_right_q && stop_left_q))
		else $error("both stop pulses raised by one item");
	a_stop_mode: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (right_res.stop || left_res.stop) |-> cfg_q.steps_mode)
		else $error("stop pulse raised outside steps mode");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the analog wheel step counter
// A clocked driver feeds tagged sample items from a queue, and a clocked
// monitor compares every result item with a cycle-free prediction of the
// wheel trackers and the goal flags. The run walks through several register
// settings, from all zero to the extremes.
// ----------------------------------------------------------------------------
module tb_top;

	// One sample item as the driver sends it.
	typedef struct packed {
		logic [awsc_pkg::KindW-1:0]   kind;
		logic [awsc_pkg::SampleW-1:0] sample;
	} sample_item_t;

	// One result item as the block should report it.
	typedef struct packed {
		logic                        goal_status;
		logic [awsc_pkg::CountW-1:0] right_steps;
		logic [awsc_pkg::CountW-1:0] left_steps;
		logic                        stop_right;
		logic                        stop_left;
	} step_result_t;

	// Tracking state of one wheel.
	typedef struct packed {
		logic [awsc_pkg::SampleW-1:0] last;
		logic                         primed;
		logic                         rising;
		logic [awsc_pkg::CountW-1:0]  count;
	} wheel_state_t;

	localparam int RIGHT = 0;
	localparam int LEFT  = 1;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        wr_en = 1'b0;
	logic [awsc_pkg::IndexW-1:0] wr_index = '0;
	logic [awsc_pkg::DataW-1:0]  wr_data = '0;

	awsc_in_if  sample_ch ();
	awsc_out_if result_ch ();

	analog_wheel_step_counter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.samples  (sample_ch),
		.results  (result_ch)
	);

	// Clock.
	always #6 clk = ~clk;

	// Register copy and tracking state of the prediction.
	awsc_pkg::cfg_t cfg_mirror;
	wheel_state_t   wheel_st [2];
	logic [7:0]     goal_l_smp, goal_r_smp;
	logic           goal_l_flag, goal_r_flag, goal_out;

	sample_item_t sample_q [$];
	step_result_t pending_results [$];

	int  n_queued = 0;
	int  n_accepted = 0;
	int  n_checked = 0;
	int  n_cfg_writes = 0;
	int  err_count = 0;
	bit  gaps_on = 1'b1;
	bit  item_taken = 1'b0;

	// Generator state of the wheel sample walks.
	logic [7:0] walk_val [2];
	bit         walk_up [2];

	// Advance one wheel on a sample; returns the stop pulse.
	function automatic logic track_wheel(input int side, input logic [7:0] s,
			input logic [15:0] target);
		wheel_state_t w;
		logic [7:0]   slope;
		logic         up;
		logic         stop;
		w = wheel_st[side];
		stop = 1'b0;
		if (!w.primed) begin
			w.last = (s > awsc_pkg::PRIME_THRESHOLD) ? awsc_pkg::PRIME_LOW
				: awsc_pkg::PRIME_HIGH;
		end
		if (s != w.last) begin
			up = s > w.last;
			slope = up ? s - w.last : w.last - s;
			w.last = s;
			if (!w.primed) begin
				w.primed = 1'b1;
				w.rising = up;
			end
			if (slope > cfg_mirror.slope_limit) begin
				if (up != w.rising) begin
					w.count = w.count + 16'd1;
					w.rising = up;
				end
				stop = cfg_mirror.steps_mode && target != '0 && w.count >= target;
			end
		end
		wheel_st[side] = w;
		return stop;
	endfunction

	// Expected result of one accepted sample item.
	function automatic step_result_t predict_step(input logic [1:0] kind,
			input logic [7:0] s);
		step_result_t r;
		logic [8:0]   th_l, th_r;
		r = '0;
		case (kind)
			awsc_pkg::KIND_GOAL_LEFT, awsc_pkg::KIND_GOAL_RIGHT: begin
				if (kind == awsc_pkg::KIND_GOAL_LEFT) goal_l_smp = s;
				else goal_r_smp = s;
				// Status lags: it reflects the flags from the previous goal update.
				goal_out = goal_l_flag & goal_r_flag;
				th_l = {1'b0, cfg_mirror.left_reference} + {1'b0, cfg_mirror.left_margin};
				th_r = {1'b0, cfg_mirror.right_reference} + {1'b0, cfg_mirror.right_margin};
				goal_l_flag = {1'b0, goal_l_smp} >= th_l;
				goal_r_flag = {1'b0, goal_r_smp} >= th_r;
			end
			awsc_pkg::KIND_RIGHT_WHEEL:
				r.stop_right = track_wheel(RIGHT, s, cfg_mirror.right_target);
			default:
				r.stop_left  = track_wheel(LEFT, s, cfg_mirror.left_target);
		endcase
		r.goal_status = goal_out;
		r.right_steps = wheel_st[RIGHT].count;
		r.left_steps  = wheel_st[LEFT].count;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Monitor and predictor: check the result item, then predict for the
	// sample item taken at this edge.
	always @(posedge clk) begin : monitor
		step_result_t want;
		item_taken <= sample_ch.valid && sample_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result item, expected none, actual %b %0d %0d %b %b",
					$time, result_ch.goal_status, result_ch.right_steps,
					result_ch.left_steps, result_ch.stop_right, result_ch.stop_left);
			end else begin
				want = pending_results.pop_front();
				check_field("goal_status", 16'(want.goal_status),
					16'(result_ch.goal_status));
				check_field("right_steps", want.right_steps, result_ch.right_steps);
				check_field("left_steps", want.left_steps, result_ch.left_steps);
				check_field("stop_right", 16'(want.stop_right), 16'(result_ch.stop_right));
				check_field("stop_left", 16'(want.stop_left), 16'(result_ch.stop_left));
				n_checked++;
			end
		end
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			pending_results.push_back(predict_step(sample_ch.kind, sample_ch.sample));
			n_accepted++;
		end
	end

	// Sample driver: a new item goes out once the previous one is taken.
	always @(negedge clk) begin : driver
		sample_item_t nxt;
		if (arst_n && (!sample_ch.valid || item_taken)) begin
			if (sample_q.size() != 0 && !(gaps_on && $urandom_range(99, 0) < 9)) begin
				nxt = sample_q.pop_front();
				sample_ch.valid  <= 1'b1;
				sample_ch.kind   <= nxt.kind;
				sample_ch.sample <= nxt.sample;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls.
	always @(negedge clk) begin
		if (arst_n)
			result_ch.ready <= !(gaps_on && $urandom_range(99, 0) < 9);
	end

	task automatic queue_item(input logic [1:0] kind, input logic [7:0] s);
		sample_q.push_back('{kind: kind, sample: s});
		n_queued++;
	endtask

	task automatic write_reg(input logic [awsc_pkg::IndexW-1:0] idx,
			input logic [awsc_pkg::DataW-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			awsc_pkg::REG_MIN_SLOPE:       cfg_mirror.slope_limit     = data[7:0];
			awsc_pkg::REG_STEPS_MODE:      cfg_mirror.steps_mode      = data[0];
			awsc_pkg::REG_RIGHT_TARGET:    cfg_mirror.right_target    = data;
			awsc_pkg::REG_LEFT_TARGET:     cfg_mirror.left_target     = data;
			awsc_pkg::REG_LEFT_REFERENCE:  cfg_mirror.left_reference  = data[7:0];
			awsc_pkg::REG_RIGHT_REFERENCE: cfg_mirror.right_reference = data[7:0];
			awsc_pkg::REG_LEFT_MARGIN:     cfg_mirror.left_margin     = data[7:0];
			default:                       cfg_mirror.right_margin    = data[7:0];
		endcase
		n_cfg_writes++;
	endtask

	// Write every register; unused upper data bits carry random junk.
	task automatic set_config(input logic [7:0] slope_limit, input logic steps,
			input logic [15:0] rt, input logic [15:0] lt,
			input logic [7:0] lref, input logic [7:0] rref,
			input logic [7:0] lmar, input logic [7:0] rmar);
		logic [15:0] junk;
		junk = 16'($urandom);
		write_reg(awsc_pkg::REG_MIN_SLOPE, {junk[15:8], slope_limit});
		write_reg(awsc_pkg::REG_STEPS_MODE, {junk[14:0], steps});
		write_reg(awsc_pkg::REG_RIGHT_TARGET, rt);
		write_reg(awsc_pkg::REG_LEFT_TARGET, lt);
		write_reg(awsc_pkg::REG_LEFT_REFERENCE, {junk[7:0], lref});
		write_reg(awsc_pkg::REG_RIGHT_REFERENCE, {junk[15:8], rref});
		write_reg(awsc_pkg::REG_LEFT_MARGIN, {junk[11:4], lmar});
		write_reg(awsc_pkg::REG_RIGHT_MARGIN, {junk[12:5], rmar});
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Wait until every queued item was taken and its result checked.
	task automatic drain;
		while (!(n_accepted == n_queued && pending_results.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random item: wheel samples mostly swing back and forth, goal samples
	// half of the time sit near the detection threshold.
	task automatic queue_random_item;
		logic [1:0] kind;
		int         side, r, th, v;
		kind = 2'($urandom_range(3, 0));
		if (kind == awsc_pkg::KIND_GOAL_LEFT || kind == awsc_pkg::KIND_GOAL_RIGHT) begin
			th = (kind == awsc_pkg::KIND_GOAL_LEFT)
				? cfg_mirror.left_reference + cfg_mirror.left_margin
				: cfg_mirror.right_reference + cfg_mirror.right_margin;
			if ($urandom_range(1, 0)) begin
				v = th + $urandom_range(6, 0) - 3;
				v = (v < 0) ? 0 : (v > 255) ? 255 : v;
			end else begin
				v = $urandom_range(255, 0);
			end
		end else begin
			side = (kind == awsc_pkg::KIND_RIGHT_WHEEL) ? RIGHT : LEFT;
			r = $urandom_range(99, 0);
			if (r < 75) begin
				v = walk_up[side] ? $urandom_range(walk_val[side], 0)
					: $urandom_range(255, walk_val[side]);
				walk_up[side] = !walk_up[side];
			end else if (r < 85) begin
				v = walk_val[side];
			end else begin
				v = $urandom_range(255, 0);
			end
			walk_val[side] = 8'(v);
		end
		queue_item(kind, 8'(v));
	endtask

	task automatic random_phase(input int count);
		repeat (count) queue_random_item();
		drain();
	endtask

	// Main sequence.
	initial begin : stimulus
		sample_ch.valid  = 1'b0;
		sample_ch.kind   = '0;
		sample_ch.sample = '0;
		result_ch.ready  = 1'b0;
		cfg_mirror  = '0;
		wheel_st[RIGHT] = '0;
		wheel_st[LEFT]  = '0;
		goal_l_smp  = '0;
		goal_r_smp  = '0;
		goal_l_flag = 1'b0;
		goal_r_flag = 1'b0;
		goal_out    = 1'b0;
		walk_val[RIGHT] = 8'd128;
		walk_val[LEFT]  = 8'd128;
		walk_up[RIGHT]  = 1'b0;
		walk_up[LEFT]   = 1'b1;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: priming, equal and small slopes, reversals, stop pulses,
		// and goal thresholds on both sides of the boundary.
		set_config(8'd10, 1'b1, 16'd3, 16'd2, 8'd100, 8'd120, 8'd20, 8'd30);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd200);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd50);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd50);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd55);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd255);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd0);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd5);
		queue_item(awsc_pkg::KIND_RIGHT_WHEEL, 8'd200);
		queue_item(awsc_pkg::KIND_LEFT_WHEEL, 8'd150);
		queue_item(awsc_pkg::KIND_LEFT_WHEEL, 8'd0);
		queue_item(awsc_pkg::KIND_LEFT_WHEEL, 8'd255);
		queue_item(awsc_pkg::KIND_LEFT_WHEEL, 8'd0);
		queue_item(awsc_pkg::KIND_LEFT_WHEEL, 8'd0);
		queue_item(awsc_pkg::KIND_GOAL_LEFT, 8'd120);
		queue_item(awsc_pkg::KIND_GOAL_RIGHT, 8'd149);
		queue_item(awsc_pkg::KIND_GOAL_RIGHT, 8'd150);
		queue_item(awsc_pkg::KIND_GOAL_LEFT, 8'd119);
		queue_item(awsc_pkg::KIND_GOAL_LEFT, 8'd255);
		queue_item(awsc_pkg::KIND_GOAL_RIGHT, 8'd0);
		queue_item(awsc_pkg::KIND_GOAL_LEFT, 8'd0);
		drain();

		// All registers at their reset values.
		set_config(8'd0, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		random_phase(370);

		// Upper extremes, with the handshakes running without gaps.
		gaps_on = 1'b0;
		set_config(8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
		random_phase(370);
		gaps_on = 1'b1;

		// Targets just ahead of the current counts so that stop pulses fire.
		set_config(8'($urandom_range(80, 0)), 1'b1,
			16'(wheel_st[RIGHT].count + $urandom_range(40, 1)),
			16'(wheel_st[LEFT].count + $urandom_range(40, 1)),
			8'($urandom), 8'($urandom),
			8'($urandom_range(40, 0)), 8'($urandom_range(40, 0)));
		random_phase(370);

		// Everything random.
		set_config(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		random_phase(370);

		set_config(8'($urandom_range(30, 0)), 1'b1,
			16'(wheel_st[RIGHT].count + $urandom_range(60, 1)),
			16'(wheel_st[LEFT].count + $urandom_range(60, 1)),
			8'($urandom), 8'($urandom), 8'd0, 8'd0);
		random_phase(350);
		repeat (10) @(posedge clk);

		$display("Sent %0d sample items over %0d register writes, %0d result items checked,",
			n_accepted, n_cfg_writes, n_checked);
		$display("covering priming, slope limits, stop targets and goal thresholds.");
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Timeout with %0d result items still pending", pending_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/awsc_pkg.sv
hw/rtl/awsc_if.sv
hw/rtl/awsc_wheel.sv
hw/rtl/awsc_goal.sv
hw/rtl/analog_wheel_step_counter.sv
tb/tb_top.sv
